// File: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the real-time clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RTC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define RTC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define RTC_ASSERT(lbl, prop, msg)
`define RTC_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// File: hdl/rtc_pkg.sv
// Package with command codes, register indexes and status bit positions of the real-time clock.
package rtc_pkg;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        REG_CONTROL  = 3'd0,
        REG_STATUS   = 3'd1,
        REG_RELOAD   = 3'd2,
        REG_DIVIDER  = 3'd3,
        REG_COUNTER  = 3'd4,
        REG_ALARM    = 3'd5
    } t_reg_index;

    localparam int DATA_WIDTH    = 32;
    localparam int NUM_FLAGS     = 4;
    localparam int NUM_ENABLES   = 3;

    // Bit positions in the flag vector and the status register.
    localparam int FLAG_SEC      = 0;
    localparam int FLAG_ALR      = 1;
    localparam int FLAG_OVF      = 2;
    localparam int FLAG_SYNC     = 3;
    localparam int STAT_CONFIG   = 4;

    typedef logic [DATA_WIDTH-1:0]  t_word;
    typedef logic [NUM_FLAGS-1:0]   t_flags;
    typedef logic [NUM_ENABLES-1:0] t_enables;

endpackage

// File: hdl/rtc_timebase.sv
// Down-counting prescaler that divides time ticks into counter increments.
module rtc_timebase #(
    parameter int PRESCALER_WIDTH = 20
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_tick,
    input  logic [PRESCALER_WIDTH-1:0] i_reload,
    output logic [PRESCALER_WIDTH-1:0] o_divider,
    output logic                       o_wrap
);

    logic [PRESCALER_WIDTH-1:0] r_divider;
    logic [PRESCALER_WIDTH-1:0] n_divider;

    // A tick that finds the divider at zero reloads it and ends one period.
    assign o_wrap    = i_tick && (r_divider == '0);
    assign o_divider = r_divider;

    always_comb begin
        n_divider = r_divider;
        if (o_wrap) begin
            n_divider = i_reload;
        end else if (i_tick) begin
            n_divider = r_divider - PRESCALER_WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divider <= '0;
        end else begin
            r_divider <= n_divider;
        end
    end

endmodule

// File: hdl/rtc_prescaled_counter_alarm_unit.sv
// Top level of the real-time clock: register file, seconds counter, alarm and interrupt.
// Each item's result is registered and becomes visible in the cycle after the item is accepted.
// Throughput is one item per cycle; a stalled result holds the input only while it is unread.
// The cycle is set by the 32-bit counter increment and the alarm compare on its sum.
// Synchronous reset: clock state cleared, alarm all ones, no result pending.
module rtc_prescaled_counter_alarm_unit #(
    parameter int PRESCALER_WIDTH = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_cmd,
    input  logic [2:0]         i_reg_index,
    input  rtc_pkg::t_word     i_write_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rtc_pkg::t_word     o_read_data,
    output logic               o_irq,
    output logic               o_write_ignored
);
    import rtc_pkg::*;

    `include "assert_macros.svh"

    logic [PRESCALER_WIDTH-1:0] r_reload;
    logic [PRESCALER_WIDTH-1:0] n_reload;
    logic [PRESCALER_WIDTH-1:0] w_divider;
    t_word                      r_seconds;
    t_word                      n_seconds;
    t_word                      r_alarm;
    t_word                      n_alarm;
    t_flags                     r_flags;
    t_flags                     n_flags;
    t_enables                   r_enables;
    t_enables                   n_enables;
    logic                       r_config;
    logic                       n_config;

    logic   r_out_valid;
    t_word  r_read_data;
    logic   r_irq;
    logic   r_write_ignored;

    logic   w_in_acc;
    logic   w_tick;
    logic   w_wrap;
    t_word  w_seconds_inc;
    t_word  w_rd;
    logic   w_ign;

    // The input waits only while a finished result is held by the consumer.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_tick     = w_in_acc && (i_cmd == CMD_TICK);

    rtc_timebase #(
        .PRESCALER_WIDTH(PRESCALER_WIDTH)
    ) u_timebase (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tick    (w_tick),
        .i_reload  (r_reload),
        .o_divider (w_divider),
        .o_wrap    (w_wrap)
    );

    assign w_seconds_inc = r_seconds + DATA_WIDTH'(1);

    always_comb begin
        n_reload  = r_reload;
        n_seconds = r_seconds;
        n_alarm   = r_alarm;
        n_flags   = r_flags;
        n_enables = r_enables;
        n_config  = r_config;
        w_rd      = '0;
        w_ign     = 1'b0;
        if (w_in_acc) begin
            unique case (i_cmd)
                CMD_TICK: begin
                    if (w_wrap) begin
                        n_seconds           = w_seconds_inc;
                        n_flags[FLAG_SEC]   = 1'b1;
                        n_flags[FLAG_SYNC]  = 1'b1;
                        if (w_seconds_inc == r_alarm) begin
                            n_flags[FLAG_ALR] = 1'b1;
                        end
                        if (w_seconds_inc == '0) begin
                            n_flags[FLAG_OVF] = 1'b1;
                        end
                    end
                end
                CMD_READ: begin
                    unique case (i_reg_index)
                        REG_CONTROL: w_rd = DATA_WIDTH'(r_enables);
                        REG_STATUS:  w_rd = {{(DATA_WIDTH-STAT_CONFIG-2){1'b0}}, 1'b1,
                                             r_config, r_flags};
                        REG_RELOAD:  w_rd = DATA_WIDTH'(r_reload);
                        REG_DIVIDER: w_rd = DATA_WIDTH'(w_divider);
                        REG_COUNTER: w_rd = r_seconds;
                        REG_ALARM:   w_rd = r_alarm;
                        default:     w_rd = '0;
                    endcase
                end
                CMD_WRITE: begin
                    unique case (i_reg_index)
                        REG_CONTROL: n_enables = i_write_data[NUM_ENABLES-1:0];
                        REG_STATUS: begin
                            // Writing zero clears a flag; writing one never sets it.
                            n_flags  = r_flags & i_write_data[NUM_FLAGS-1:0];
                            n_config = i_write_data[STAT_CONFIG];
                        end
                        REG_RELOAD: begin
                            if (r_config) begin
                                n_reload = i_write_data[PRESCALER_WIDTH-1:0];
                            end else begin
                                w_ign = 1'b1;
                            end
                        end
                        REG_COUNTER: begin
                            if (r_config) begin
                                n_seconds = i_write_data;
                            end else begin
                                w_ign = 1'b1;
                            end
                        end
                        REG_ALARM: begin
                            if (r_config) begin
                                n_alarm = i_write_data;
                            end else begin
                                w_ign = 1'b1;
                            end
                        end
                        default: w_ign = 1'b1;
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reload    <= '0;
            r_seconds   <= '0;
            r_alarm     <= '1;
            r_flags     <= '0;
            r_enables   <= '0;
            r_config    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_reload  <= n_reload;
            r_seconds <= n_seconds;
            r_alarm   <= n_alarm;
            r_flags   <= n_flags;
            r_enables <= n_enables;
            r_config  <= n_config;
            if (w_in_acc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_read_data     <= w_rd;
            r_irq           <= |(n_flags[NUM_ENABLES-1:0] & n_enables);
            r_write_ignored <= w_ign;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_read_data     = r_read_data;
    assign o_irq           = r_irq;
    assign o_write_ignored = r_write_ignored;

    `RTC_ASSERT(a_stall_only_when_full, o_in_stall |-> o_out_valid, "input stalled with no result held")
    `RTC_ASSERT(a_ignored_reads_zero, (o_out_valid && o_write_ignored) |-> (o_read_data == '0), "refused write carries read data")
    `RTC_ASSERT(a_locked_counter, (w_in_acc && i_cmd == CMD_WRITE && i_reg_index == REG_COUNTER && !r_config) |=> $stable(r_seconds), "counter changed by a protected write")
    `RTC_ASSERT(a_irq_from_flags, (w_in_acc && n_flags[NUM_ENABLES-1:0] == '0) |=> !o_irq, "interrupt raised with no event flag")
    `RTC_ASSERT_RST(a_reset_state, !i_rst_n |=> (!r_config && r_alarm == '1 && !o_out_valid), "reset state wrong")

endmodule

// File: sim/rtc_prescaled_counter_alarm_unit_test.sv
// Self-checking testbench of the real-time clock with prescaler, seconds counter and alarm.
module rtc_prescaled_counter_alarm_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rtc_pkg::*;

    localparam int PRE_W = 20;
    localparam int CYCLE_LIMIT = 200000;
    localparam int STAT_WDONE = 5;

    // Codes that the package leaves unnamed but the block still has to handle.
    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    localparam t_word CFG_MODE_BIT = t_word'(1) << STAT_CONFIG;

    typedef struct packed {
        t_word read_data;
        logic  irq;
        logic  write_ignored;
    } t_rtc_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_cmd;
    logic [2:0]  i_reg_index;
    t_word       i_write_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_word       o_read_data;
    logic        o_irq;
    logic        o_write_ignored;

    // Predicted clock state, updated as each item is accepted.
    logic [PRE_W-1:0] shadow_reload;
    logic [PRE_W-1:0] shadow_divider;
    t_word            shadow_seconds;
    t_word            shadow_alarm;
    t_flags           shadow_flags;
    t_enables         shadow_enables;
    logic             shadow_cfg;

    t_rtc_result rtc_results_due[$];
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int          hold_cycles = 0;
    bit          send_gaps = 1'b0;
    bit          sink_gaps = 1'b0;

    rtc_prescaled_counter_alarm_unit #(
        .PRESCALER_WIDTH(PRE_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_reg_index    (i_reg_index),
        .i_write_data   (i_write_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_read_data    (o_read_data),
        .o_irq          (o_irq),
        .o_write_ignored(o_write_ignored)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: a forced hold-off takes priority over random stalls.
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            hold_cycles--;
        end else if (sink_gaps) begin
            i_out_stall <= ($urandom_range(99) < 19);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic report_mismatch(input string field, input t_word got, input t_word want);
        mismatches++;
        $display("ERROR: %s got %h, predicted %h (cycle %0d)", field, got, want, cycle_count);
    endtask

    always @(posedge i_clk) begin : check_results
        t_rtc_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (rtc_results_due.size() == 0) begin
                report_mismatch("unexpected result, read_data", o_read_data, '0);
            end else begin
                want = rtc_results_due.pop_front();
                if (o_read_data !== want.read_data)
                    report_mismatch("read_data", o_read_data, want.read_data);
                if (o_irq !== want.irq)
                    report_mismatch("irq", t_word'(o_irq), t_word'(want.irq));
                if (o_write_ignored !== want.write_ignored)
                    report_mismatch("write_ignored", t_word'(o_write_ignored),
                                    t_word'(want.write_ignored));
            end
        end
    end

    function automatic t_rtc_result predict_rtc_result(input logic [1:0] cmd,
                                                      input logic [2:0] idx,
                                                      input t_word data);
        t_rtc_result r;
        r = '0;
        case (cmd)
            CMD_TICK: begin
                if (shadow_divider == '0) begin
                    shadow_divider = shadow_reload;
                    shadow_seconds = shadow_seconds + 1'b1;
                    shadow_flags[FLAG_SEC] = 1'b1;
                    shadow_flags[FLAG_SYNC] = 1'b1;
                    if (shadow_seconds == shadow_alarm)
                        shadow_flags[FLAG_ALR] = 1'b1;
                    if (shadow_seconds == '0)
                        shadow_flags[FLAG_OVF] = 1'b1;
                end else begin
                    shadow_divider = shadow_divider - 1'b1;
                end
            end
            CMD_READ: begin
                case (idx)
                    REG_CONTROL: r.read_data = t_word'(shadow_enables);
                    REG_STATUS: begin
                        r.read_data = t_word'(shadow_flags);
                        r.read_data[STAT_CONFIG] = shadow_cfg;
                        r.read_data[STAT_WDONE] = 1'b1;
                    end
                    REG_RELOAD:  r.read_data = t_word'(shadow_reload);
                    REG_DIVIDER: r.read_data = t_word'(shadow_divider);
                    REG_COUNTER: r.read_data = shadow_seconds;
                    REG_ALARM:   r.read_data = shadow_alarm;
                    default:     r.read_data = '0;
                endcase
            end
            CMD_WRITE: begin
                case (idx)
                    REG_CONTROL: shadow_enables = data[NUM_ENABLES-1:0];
                    REG_STATUS: begin
                        shadow_flags = shadow_flags & data[NUM_FLAGS-1:0];
                        shadow_cfg = data[STAT_CONFIG];
                    end
                    REG_RELOAD: begin
                        if (shadow_cfg) shadow_reload = data[PRE_W-1:0];
                        else r.write_ignored = 1'b1;
                    end
                    REG_COUNTER: begin
                        if (shadow_cfg) shadow_seconds = data;
                        else r.write_ignored = 1'b1;
                    end
                    REG_ALARM: begin
                        if (shadow_cfg) shadow_alarm = data;
                        else r.write_ignored = 1'b1;
                    end
                    default: r.write_ignored = 1'b1;
                endcase
            end
            default: ;
        endcase
        r.irq = |(shadow_flags[NUM_ENABLES-1:0] & shadow_enables);
        return r;
    endfunction

    // Offers one item, holds it while stalled and records its predicted result.
    task automatic send_item(input logic [1:0] cmd, input logic [2:0] idx, input t_word data);
        if (send_gaps) begin
            while ($urandom_range(99) < 19) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_reg_index <= idx;
        i_write_data <= data;
        do @(posedge i_clk); while (o_in_stall);
        rtc_results_due.push_back(predict_rtc_result(cmd, idx, data));
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (rtc_results_due.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic test_reset_state();
        send_item(CMD_READ, REG_STATUS, '0);
        send_item(CMD_READ, REG_ALARM, '0);
        send_item(CMD_READ, REG_SPARE_HI, '0);
        send_item(CMD_NONE, REG_COUNTER, 32'hFFFF_FFFF);
    endtask

    task automatic test_write_protection();
        send_item(CMD_WRITE, REG_RELOAD, 32'h0000_0005);
        send_item(CMD_WRITE, REG_COUNTER, 32'h1234_5678);
        send_item(CMD_WRITE, REG_DIVIDER, 32'hFFFF_FFFF);
        send_item(CMD_WRITE, REG_SPARE_LO, 32'hFFFF_FFFF);
        // Ones in the flag bits must not raise any flag; bit 4 enters config mode.
        send_item(CMD_WRITE, REG_STATUS, 32'hFFFF_FFFF);
        send_item(CMD_WRITE, REG_RELOAD, 32'hFFFF_FFFF);
        send_item(CMD_READ, REG_RELOAD, '0);
    endtask

    task automatic test_alarm_and_overflow();
        send_item(CMD_WRITE, REG_RELOAD, '0);
        send_item(CMD_WRITE, REG_COUNTER, 32'hFFFF_FFFE);
        send_item(CMD_WRITE, REG_ALARM, 32'hFFFF_FFFF);
        send_item(CMD_WRITE, REG_CONTROL, 32'hFFFF_FFFF);
        // The divider is still zero, so each tick wraps: first the alarm, then the overflow.
        send_item(CMD_TICK, REG_CONTROL, '0);
        send_item(CMD_TICK, REG_CONTROL, '0);
        send_item(CMD_READ, REG_STATUS, '0);
        send_item(CMD_WRITE, REG_STATUS, CFG_MODE_BIT);
    endtask

    task automatic test_prescaler();
        send_item(CMD_WRITE, REG_RELOAD, 32'h0000_0002);
        send_item(CMD_TICK, REG_CONTROL, '0);
        send_item(CMD_READ, REG_DIVIDER, '0);
        send_item(CMD_TICK, REG_CONTROL, '0);
        send_item(CMD_TICK, REG_CONTROL, '0);
        send_item(CMD_TICK, REG_CONTROL, '0);
        send_item(CMD_READ, REG_COUNTER, '0);
        send_item(CMD_WRITE, REG_STATUS, '0);
    endtask

    task automatic run_random_traffic(input int count);
        int    sent;
        int    pick;
        t_word data;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(99);
            data = $urandom;
            if (pick < 40) begin
                send_item(CMD_TICK, 3'($urandom_range(7)), data);
            end else if (pick < 55) begin
                send_item(CMD_READ, 3'($urandom_range(7)), data);
            end else if (pick < 63) begin
                if ($urandom_range(99) < 80) data[STAT_CONFIG] = 1'b1;
                send_item(CMD_WRITE, REG_STATUS, data);
            end else if (pick < 68) begin
                send_item(CMD_WRITE, REG_CONTROL, data);
            end else if (pick < 74) begin
                // Short periods keep the seconds counter moving; high bits are dropped.
                data[PRE_W-1:0] = PRE_W'($urandom_range(5));
                send_item(CMD_WRITE, REG_RELOAD, data);
            end else if (pick < 80) begin
                case ($urandom_range(2))
                    0: data = shadow_alarm - t_word'($urandom_range(1, 3));
                    1: data = 32'hFFFF_FFFF - t_word'($urandom_range(2));
                    default: ;
                endcase
                send_item(CMD_WRITE, REG_COUNTER, data);
            end else if (pick < 86) begin
                if ($urandom_range(3) != 0)
                    data = shadow_seconds + t_word'($urandom_range(3));
                send_item(CMD_WRITE, REG_ALARM, data);
            end else if (pick < 89) begin
                send_item(CMD_WRITE, 3'($urandom_range(1)) ? REG_DIVIDER : REG_SPARE_HI, data);
            end else if (pick < 92) begin
                send_item(CMD_NONE, 3'($urandom_range(7)), data);
            end else if (pick < 94) begin
                // A full-width reload is replaced by a short one before any tick can load it.
                send_item(CMD_WRITE, REG_STATUS, data | CFG_MODE_BIT);
                send_item(CMD_WRITE, REG_RELOAD, $urandom);
                send_item(CMD_READ, REG_RELOAD, data);
                send_item(CMD_WRITE, REG_RELOAD, t_word'($urandom_range(3)));
                sent += 3;
            end else begin
                send_item(CMD_TICK, REG_CONTROL, data);
            end
            sent++;
        end
    endtask

    // The result side holds off while items keep coming, so the block must stall its input.
    task automatic test_output_backpressure();
        hold_cycles = 150;
        run_random_traffic(40);
        drain_results();
    endtask

    initial begin
        shadow_reload = '0;
        shadow_divider = '0;
        shadow_seconds = '0;
        shadow_alarm = '1;
        shadow_flags = '0;
        shadow_enables = '0;
        shadow_cfg = 1'b0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_cmd <= CMD_TICK;
        i_reg_index <= REG_CONTROL;
        i_write_data <= '0;
        i_out_stall <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_gaps = 1'b1;
        sink_gaps = 1'b1;
        test_reset_state();
        test_write_protection();
        test_alarm_and_overflow();
        test_prescaler();
        drain_results();

        run_random_traffic(600);
        drain_results();
        test_output_backpressure();

        send_gaps = 1'b0;
        sink_gaps = 1'b0;
        run_random_traffic(300);
        drain_results();

        send_gaps = 1'b1;
        sink_gaps = 1'b1;
        run_random_traffic(500);
        drain_results();
        repeat (4) @(posedge i_clk);

        if (mismatches == 0 && rtc_results_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
